@@ src/twd_pkg.sv @@
package twd_pkg;

    // Saturation bound for counts and height
    localparam int C_MAX_SITES = 1048576;

    localparam logic signed [22:0] C_H_MAX = 23'(C_MAX_SITES);
    localparam logic signed [22:0] C_H_MIN = -23'(C_MAX_SITES);
    localparam logic [20:0]        C_CNT_MAX = 21'(C_MAX_SITES);

    // One aligned site as held in the input register
    typedef struct packed {
        logic [3:0] a_code;
        logic [3:0] b_code;
        logic [3:0] c_code;
        logic       gap;
        logic       last;
    } t_site;

    // Statistics of one finished triplet
    typedef struct packed {
        logic [20:0] up_count;
        logic [20:0] down_count;
        logic [20:0] peak_height;
        logic [21:0] largest_descent;
        logic [21:0] descent_floor_height;
    } t_stats;

endpackage

@@ src/twd_in_stage.sv @@
module twd_in_stage
    import twd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_parent_a_code,
    input  logic [3:0] i_parent_b_code,
    input  logic [3:0] i_child_code,
    input  logic       i_parent_a_gap,
    input  logic       i_parent_b_gap,
    input  logic       i_child_gap,
    input  logic       i_last_site,
    input  logic       i_take,
    output logic       o_site_valid,
    output t_site      o_site
);

    logic  r_valid;
    t_site r_site;

    // Accept a new site when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the payload; gap flags fold into one skip flag
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_site.a_code <= i_parent_a_code;
            r_site.b_code <= i_parent_b_code;
            r_site.c_code <= i_child_code;
            r_site.gap    <= i_parent_a_gap | i_parent_b_gap | i_child_gap;
            r_site.last   <= i_last_site;
        end
    end

    assign o_site_valid = r_valid;
    assign o_site       = r_site;

endmodule

@@ src/twd_walk.sv @@
module twd_walk
    import twd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_site_valid,
    input  t_site  i_site,
    output logic   o_take,
    output logic   o_valid,
    input  logic   i_ready,
    output t_stats o_stats
);

    logic signed [21:0] r_height;
    logic [20:0]        r_peak;
    logic [20:0]        r_ups;
    logic [20:0]        r_downs;
    logic [21:0]        r_best;
    logic signed [21:0] r_best_h;
    logic               r_out_valid;
    t_stats             r_stats;

    logic signed [22:0] n_height;
    logic signed [22:0] n_peak;
    logic signed [22:0] n_diff;
    logic [20:0]        n_ups;
    logic [20:0]        n_downs;
    logic [21:0]        n_best;
    logic signed [21:0] n_best_h;
    logic               up_step;
    logic               down_step;
    logic signed [22:0] cur_h;
    logic signed [22:0] cur_peak;

    // A last site may only move on when the result register is free or is being emptied this cycle
    assign o_take = i_site_valid &&
                    !(i_site.last && r_out_valid && !i_ready);

    // Step classification of the held site
    always_comb begin
        up_step   = !i_site.gap && (i_site.a_code == i_site.c_code) &&
                    (i_site.b_code != i_site.c_code);
        down_step = !i_site.gap && (i_site.a_code != i_site.c_code) &&
                    (i_site.b_code == i_site.c_code);
    end

    // Advance the walk with saturation, then peak and descent
    always_comb begin
        cur_h    = $signed({r_height[21], r_height});
        cur_peak = $signed({2'b00, r_peak});
        n_height = cur_h;
        n_ups    = r_ups;
        n_downs  = r_downs;
        if (up_step) begin
            if (cur_h < C_H_MAX) n_height = cur_h + 23'sd1;
            if (r_ups < C_CNT_MAX) n_ups = r_ups + 21'd1;
        end else if (down_step) begin
            if (cur_h > C_H_MIN) n_height = cur_h - 23'sd1;
            if (r_downs < C_CNT_MAX) n_downs = r_downs + 21'd1;
        end
        n_peak = (n_height > cur_peak) ? n_height : cur_peak;
        n_diff = n_peak - n_height;
        n_best   = r_best;
        n_best_h = r_best_h;
        if (!i_site.gap && (n_diff > $signed({1'b0, r_best}))) begin
            n_best   = n_diff[21:0];
            n_best_h = n_height[21:0];
        end
    end

    // Update walk state; clear it after the last site
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
            r_peak   <= '0;
            r_ups    <= '0;
            r_downs  <= '0;
            r_best   <= '0;
            r_best_h <= '0;
        end else if (o_take) begin
            if (i_site.last) begin
                r_height <= '0;
                r_peak   <= '0;
                r_ups    <= '0;
                r_downs  <= '0;
                r_best   <= '0;
                r_best_h <= '0;
            end else begin
                r_height <= n_height[21:0];
                r_peak   <= n_peak[20:0];
                r_ups    <= n_ups;
                r_downs  <= n_downs;
                r_best   <= n_best;
                r_best_h <= n_best_h;
            end
        end
    end

    // Result register: load on a last site, drop on output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_site.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_site.last) begin
            r_stats.up_count             <= n_ups;
            r_stats.down_count           <= n_downs;
            r_stats.peak_height          <= n_peak[20:0];
            r_stats.largest_descent      <= n_best;
            r_stats.descent_floor_height <= n_best_h;
        end
    end

    assign o_valid = r_out_valid;
    assign o_stats = r_stats;

endmodule

@@ src/triplet_walk_drawdown_top.sv @@
// Step-walk statistics of one aligned triplet (parent A, parent B, child).
//
// Input channel: i_valid / o_ready carry one alignment site per transfer:
// three 4-bit codes, three gap flags and i_last_site. Output channel:
// o_valid / i_ready carry one statistics result per triplet, sent only
// for the site marked last.
//
// Throughput: one site per cycle, unless a last site is held back by a
// result not yet taken (see below). Each site passes an input register,
// then the compare/increment logic that updates the walk state and, on
// a last site, loads the result register. o_valid rises once the last
// site has passed the input register and loaded the result register.
//
// Reset clears the walk state and both valid flags. When the receiver
// stalls, sites that are not last keep flowing; a last site waits in the
// input register until the pending result is taken, and input stalls
// behind it.
module triplet_walk_drawdown_top
    import twd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_parent_a_code,
    input  logic [3:0]  i_parent_b_code,
    input  logic [3:0]  i_child_code,
    input  logic        i_parent_a_gap,
    input  logic        i_parent_b_gap,
    input  logic        i_child_gap,
    input  logic        i_last_site,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_up_count,
    output logic [20:0] o_down_count,
    output logic [20:0] o_peak_height,
    output logic [21:0] o_largest_descent,
    output logic [21:0] o_descent_floor_height
);

    logic   site_valid;
    t_site  site;
    logic   take;
    t_stats stats;

    twd_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_parent_a_code (i_parent_a_code),
        .i_parent_b_code (i_parent_b_code),
        .i_child_code    (i_child_code),
        .i_parent_a_gap  (i_parent_a_gap),
        .i_parent_b_gap  (i_parent_b_gap),
        .i_child_gap     (i_child_gap),
        .i_last_site     (i_last_site),
        .i_take          (take),
        .o_site_valid    (site_valid),
        .o_site          (site)
    );

    twd_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_site_valid (site_valid),
        .i_site       (site),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_stats      (stats)
    );

    assign o_up_count             = stats.up_count;
    assign o_down_count           = stats.down_count;
    assign o_peak_height          = stats.peak_height;
    assign o_largest_descent      = stats.largest_descent;
    assign o_descent_floor_height = stats.descent_floor_height;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import twd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;

    // One aligned site as offered on the input ports
    typedef struct packed {
        logic [3:0] a_code;
        logic [3:0] b_code;
        logic [3:0] c_code;
        logic       a_gap;
        logic       b_gap;
        logic       c_gap;
        logic       last;
    } t_aligned_site;

    typedef enum {STEP_UP, STEP_DOWN, STEP_FLAT, STEP_GAPPED, STEP_NOISE} t_step_kind;

    // Walk predictor plus the queue of statistics still owed by the block
    class t_drawdown_predictor;
        logic signed [22:0] height;
        logic signed [22:0] peak;
        logic signed [22:0] drop;
        logic signed [22:0] floor_height;
        logic [20:0]        ups;
        logic [20:0]        downs;
        t_stats             stats_due[$];
        int                 errors;
        int                 sites_seen;
        int                 stats_owed;
        int                 stats_checked;

        function new();
            errors = 0;
            sites_seen = 0;
            stats_owed = 0;
            stats_checked = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            height = '0;
            peak = '0;
            drop = '0;
            floor_height = '0;
            ups = '0;
            downs = '0;
        endfunction

        function int due_count();
            return stats_due.size();
        endfunction

        // Advance the walk by one transferred site; queue stats on a last site
        function void note_site(t_aligned_site s);
            t_stats e;
            sites_seen++;
            if (!(s.a_gap || s.b_gap || s.c_gap)) begin
                if (s.a_code == s.c_code && s.b_code != s.c_code) begin
                    if (height < C_H_MAX) height++;
                    if (ups < C_CNT_MAX) ups++;
                end else if (s.a_code != s.c_code && s.b_code == s.c_code) begin
                    if (height > C_H_MIN) height--;
                    if (downs < C_CNT_MAX) downs++;
                end
                if (height > peak) peak = height;
                if (peak - height > drop) begin
                    drop = peak - height;
                    floor_height = height;
                end
            end
            if (s.last) begin
                e.up_count = ups;
                e.down_count = downs;
                e.peak_height = peak[20:0];
                e.largest_descent = drop[21:0];
                e.descent_floor_height = floor_height[21:0];
                stats_due = {stats_due, e};
                stats_owed++;
                clear_walk();
            end
        endfunction

        function void cmp_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Compare one transferred result against the oldest expectation
        function void check_stats(t_stats got);
            t_stats e;
            if (stats_due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: expected none, actual %p",
                         $time, got);
                return;
            end
            e = stats_due.pop_front();
            stats_checked++;
            cmp_field("up_count", e.up_count, got.up_count);
            cmp_field("down_count", e.down_count, got.down_count);
            cmp_field("peak_height", e.peak_height, got.peak_height);
            cmp_field("largest_descent", e.largest_descent, got.largest_descent);
            cmp_field("descent_floor_height", longint'($signed(e.descent_floor_height)),
                      longint'($signed(got.descent_floor_height)));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_parent_a_code = '0;
    logic [3:0]  i_parent_b_code = '0;
    logic [3:0]  i_child_code = '0;
    logic        i_parent_a_gap = 1'b0;
    logic        i_parent_b_gap = 1'b0;
    logic        i_child_gap = 1'b0;
    logic        i_last_site = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [20:0] o_up_count;
    logic [20:0] o_down_count;
    logic [20:0] o_peak_height;
    logic [21:0] o_largest_descent;
    logic [21:0] o_descent_floor_height;

    t_drawdown_predictor sb;
    int tx_idle_pct = 35;
    int rx_idle_pct = 58;
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int items_sent = 0;
    int quiet = 0;
    int phase_goal [3] = '{300, 580, 870};

    triplet_walk_drawdown_top u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_parent_a_code        (i_parent_a_code),
        .i_parent_b_code        (i_parent_b_code),
        .i_child_code           (i_child_code),
        .i_parent_a_gap         (i_parent_a_gap),
        .i_parent_b_gap         (i_parent_b_gap),
        .i_child_gap            (i_child_gap),
        .i_last_site            (i_last_site),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_up_count             (o_up_count),
        .o_down_count           (o_down_count),
        .o_peak_height          (o_peak_height),
        .o_largest_descent      (o_largest_descent),
        .o_descent_floor_height (o_descent_floor_height)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Build a site; gaps are {parent A, parent B, child}
    function automatic t_aligned_site site(logic [3:0] a, logic [3:0] b, logic [3:0] c,
                                           logic [2:0] gaps, logic last);
        t_aligned_site s;
        s.a_code = a;
        s.b_code = b;
        s.c_code = c;
        {s.a_gap, s.b_gap, s.c_gap} = gaps;
        s.last = last;
        return s;
    endfunction

    function automatic t_aligned_site make_site(t_step_kind kind, logic last);
        logic [3:0] c;
        logic [2:0] gaps;
        c = 4'($urandom_range(15));
        gaps = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'b000;
        case (kind)
            STEP_UP: begin
                return site(c, c ^ 4'($urandom_range(1, 15)), c, 3'b000, last);
            end
            STEP_DOWN: begin
                return site(c ^ 4'($urandom_range(1, 15)), c, c, 3'b000, last);
            end
            STEP_FLAT: begin
                if ($urandom_range(1) == 0) return site(c, c, c, 3'b000, last);
                return site(c ^ 4'($urandom_range(1, 15)), c ^ 4'($urandom_range(1, 15)),
                            c, 3'b000, last);
            end
            STEP_GAPPED: begin
                return site(4'($urandom_range(15)), 4'($urandom_range(15)), c,
                            3'($urandom_range(1, 7)), last);
            end
            default: begin
                return site(4'($urandom_range(15)), 4'($urandom_range(15)), c, gaps, last);
            end
        endcase
    endfunction

    // Offer one site after a random gap and hold it until the transfer
    task automatic send_site(t_aligned_site s);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_parent_a_code <= s.a_code;
        i_parent_b_code <= s.b_code;
        i_child_code    <= s.c_code;
        i_parent_a_gap  <= s.a_gap;
        i_parent_b_gap  <= s.b_gap;
        i_child_gap     <= s.c_gap;
        i_last_site     <= s.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // One well-formed triplet with a random up/down bias and some noise
    task automatic send_random_triplet(int max_len);
        int len;
        int up_pct;
        int roll;
        t_step_kind kind;
        len = $urandom_range(1, max_len);
        up_pct = $urandom_range(10, 90);
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99);
            if (roll < 8) kind = STEP_GAPPED;
            else if (roll < 12) kind = STEP_NOISE;
            else if (roll < 18) kind = STEP_FLAT;
            else if ($urandom_range(99) < up_pct) kind = STEP_UP;
            else kind = STEP_DOWN;
            send_site(make_site(kind, i == len - 1));
        end
    endtask

    // Drop valid and hold off until every owed result has been checked
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_count() != 0) @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, or a long hold when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitor both channels at the clock edge
    always @(posedge i_clk) begin : monitor
        t_aligned_site seen;
        t_stats got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                seen = site(i_parent_a_code, i_parent_b_code, i_child_code,
                            {i_parent_a_gap, i_parent_b_gap, i_child_gap}, i_last_site);
                sb.note_site(seen);
            end
            if (o_valid && i_ready) begin
                got.up_count = o_up_count;
                got.down_count = o_down_count;
                got.peak_height = o_peak_height;
                got.largest_descent = o_largest_descent;
                got.descent_floor_height = o_descent_floor_height;
                sb.check_stats(got);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lone last site with no step: all zero, no descent
        send_site(site(4'h5, 4'h5, 4'h5, 3'b000, 1'b1));
        // Climb, fall below zero, single-sequence gaps, flat sites, a step up, gapped last site
        send_site(site(4'hF, 4'h0, 4'hF, 3'b000, 1'b0));
        send_site(site(4'hF, 4'h0, 4'hF, 3'b000, 1'b0));
        send_site(site(4'hF, 4'h0, 4'h0, 3'b000, 1'b0));
        send_site(site(4'h0, 4'hF, 4'hF, 3'b000, 1'b0));
        send_site(site(4'h0, 4'hF, 4'hF, 3'b000, 1'b0));
        send_site(site(4'hF, 4'h0, 4'hF, 3'b100, 1'b0));
        send_site(site(4'hF, 4'h0, 4'hF, 3'b010, 1'b0));
        send_site(site(4'hF, 4'h0, 4'hF, 3'b001, 1'b0));
        send_site(site(4'h1, 4'h2, 4'h3, 3'b000, 1'b0));
        send_site(site(4'h0, 4'h0, 4'h0, 3'b000, 1'b0));
        send_site(site(4'hA, 4'h3, 4'hA, 3'b000, 1'b0));
        send_site(site(4'hF, 4'h0, 4'hF, 3'b111, 1'b1));
        // Fall from zero; equal descent later must not move the floor height
        send_site(site(4'h3, 4'h7, 4'h7, 3'b000, 1'b0));
        send_site(site(4'h3, 4'h7, 4'h7, 3'b000, 1'b0));
        send_site(site(4'h7, 4'h3, 4'h7, 3'b000, 1'b0));
        send_site(site(4'h0, 4'hF, 4'hF, 3'b000, 1'b1));
        // Pure climb: peak without descent
        send_site(site(4'h0, 4'hF, 4'h0, 3'b000, 1'b0));
        send_site(site(4'h0, 4'hF, 4'h0, 3'b000, 1'b1));
        drain_results();

        // Random triplets over three idling phases, draining between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 35; rx_idle_pct = 58; end
                1: begin tx_idle_pct = 58; rx_idle_pct = 35; end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // Stall the receiver while short triplets pile up at the input
                    rx_hold_req = 1'b1;
                    repeat (6) send_random_triplet(3);
                end
            endcase
            while (items_sent < phase_goal[phase] || (phase == 2 && sb.stats_owed < 40))
                send_random_triplet(($urandom_range(99) < 85) ? 24 : 120);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.due_count() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.due_count());
        end
        $display("Covered %0d sites and %0d triplet results", sb.sites_seen, sb.stats_checked);
        $display("over three back-pressure mixes, a long output stall and drain pauses");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
